>>> design/stepper_step_generator_macros.svh
// Assertion macros used by the step generator controller.
`ifndef STEPPER_STEP_GENERATOR_MACROS_SVH
`define STEPPER_STEP_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssg assertion failed");

// Next-cycle implication, disabled during reset.
`define SSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssg assertion failed");

`endif

>>> design/ssg_pkg.sv
// Types and constants of the step generator.
`default_nettype none
package ssg_pkg;

  typedef enum logic [3:0] {
    OP_TICK        = 4'd0,
    OP_SET_SPEED   = 4'd1,
    OP_SET_DIR     = 4'd2,
    OP_STEP_COUNT  = 4'd3,
    OP_MOVE_TO     = 4'd4,
    OP_RUN         = 4'd5,
    OP_STOP        = 4'd6,
    OP_HOME        = 4'd7,
    OP_ESTOP       = 4'd8,
    OP_CLEAR_ESTOP = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_HOME  = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CORE_CLOCK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MICROSTEP  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_W    = 2'd2;

  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned MicroW     = 9;
  localparam int unsigned PulseW     = 16;
  localparam int unsigned ClockW     = 32;
  localparam int unsigned SpmW       = 17;   // 200 * microstep
  localparam int unsigned DivisorW   = SpmW + 32;
  localparam int unsigned ScaledW    = 38;   // 60 * 32-bit quotient
  localparam int unsigned StepsPerRev = 200;
  localparam int unsigned RpmScale    = 60;

  localparam logic [ClockW-1:0] CORE_CLOCK_RST = 32'd16000000;
  localparam logic [MicroW-1:0] MICROSTEP_RST  = 9'd1;
  localparam logic [PulseW-1:0] PULSE_W_RST    = 16'd10;
  localparam int unsigned PeriodRst = 96000;

  typedef struct packed {
    logic apply_op;
    logic start_speed;
    logic mul;
    logic div_step;
    logic scale;
    logic commit_speed;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic speed_req;
    logic div_last;
  } stat_t;

  typedef struct packed {
    logic        step_out;
    logic        dir_out;
    logic        enable_n;
    logic        busy_res;
    logic [31:0] position;
    logic        estop_latched;
    logic [31:0] period_ticks;
  } res_t;

endpackage
`default_nettype wire

>>> design/ssg_in_if.sv
// Request channel of the step generator.
`default_nettype none
interface ssg_in_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  operation;
  logic signed [31:0] argument;
  logic               home_sw;

  modport source (output valid, operation, argument, home_sw, input ready);
  modport sink   (input valid, operation, argument, home_sw, output ready);
endinterface
`default_nettype wire

>>> design/ssg_out_if.sv
// Result channel of the step generator.
`default_nettype none
interface ssg_out_if;
  logic               valid;
  logic               ready;
  logic               step_out;
  logic               dir_out;
  logic               enable_n;
  logic               busy_res;
  logic signed [31:0] position;
  logic               estop_latched;
  logic        [31:0] period_ticks;

  modport source (output valid, step_out, dir_out, enable_n, busy_res, position,
                  estop_latched, period_ticks, input ready);
  modport sink   (input valid, step_out, dir_out, enable_n, busy_res, position,
                  estop_latched, period_ticks, output ready);
endinterface
`default_nettype wire

>>> design/ssg_datapath.sv
// Motion state, speed divider and result register of the step generator.
`default_nettype none
module ssg_datapath #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [ssg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [ssg_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire  [3:0]                     operation_i,
  input  wire  [31:0]                    argument_i,
  input  wire                            home_sw_i,
  input  ssg_pkg::cmd_t                  cmd_i,
  output ssg_pkg::stat_t                 stat_o,
  output ssg_pkg::res_t                  res_o
);
  import ssg_pkg::*;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned WideW    = (COUNT_WIDTH > ScaledW) ? COUNT_WIDTH : ScaledW;
  localparam int unsigned PerW     = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // configuration
  logic [ClockW-1:0] core_clock_q;
  logic [MicroW-1:0] micro_q;
  logic [PulseW-1:0] pulse_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_clock_q <= CORE_CLOCK_RST;
      micro_q      <= MICROSTEP_RST;
      pulse_w_q    <= PULSE_W_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CORE_CLOCK: core_clock_q <= cfg_data_i;
        CFG_MICROSTEP:  micro_q      <= cfg_data_i[MicroW-1:0];
        CFG_PULSE_W:    pulse_w_q    <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // motion state
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic [31:0]            steps_q, steps_d;
  logic [31:0]            pos_q, pos_d;
  logic                   dir_q, dir_d;
  mode_e                  mode_q, mode_d;
  logic                   estop_q, estop_d;

  // speed unit
  logic [31:0]            rpm_q;
  logic [SpmW-1:0]        spm_q;
  logic [DivisorW-1:0]    divisor_q;
  logic [31:0]            rem_q, rem_d;
  logic [31:0]            quo_q, quo_d;
  logic [CntW-1:0]        cnt_q;
  logic [COUNT_WIDTH-1:0] scaled_q;
  res_t                   res_q, res_d;

  logic                   can_move;
  logic [31:0]            span;
  logic [31:0]            steps_n;
  logic [32:0]            trial;
  logic [DivisorW-1:0]    trial_ext;
  logic [DivisorW-1:0]    trial_sub;
  logic [ScaledW-1:0]     prod;
  logic [WideW-1:0]       prod_ext;
  logic [WideW-1:0]       mask_ext;
  logic [COUNT_WIDTH-1:0] scaled_d;
  logic [MicroW-1:0]      micro_eff;
  logic [31:0]            rpm_abs;
  logic [COUNT_WIDTH-1:0] pulse_ext;
  logic [PerW-1:0]        period_ext;
  logic                   busy_d;

  assign pulse_ext = COUNT_WIDTH'(pulse_w_q);
  assign micro_eff = (micro_q == '0) ? MicroW'(1) : micro_q;
  assign rpm_abs   = argument_i[31] ? (~argument_i + 32'd1) : argument_i;

  assign stat_o.speed_req = (operation_i == OP_SET_SPEED) && (argument_i != '0);
  assign stat_o.div_last  = (cnt_q == CntW'(DivSteps - 1));

  // restoring divider, one quotient bit per step
  assign trial     = {rem_q, quo_q[31]};
  assign trial_ext = DivisorW'(trial);
  assign trial_sub = trial_ext - divisor_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.mul) begin
      rem_d = '0;
      quo_d = core_clock_q;
    end else if (cmd_i.div_step) begin
      if (trial_ext >= divisor_q) begin
        rem_d = trial_sub[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  // period = 60 * quotient, saturated to the counter range
  assign prod     = ScaledW'(quo_q) * ScaledW'(RpmScale);
  assign prod_ext = WideW'(prod);
  assign mask_ext = WideW'({COUNT_WIDTH{1'b1}});
  assign scaled_d = (prod_ext > mask_ext) ? {COUNT_WIDTH{1'b1}} : prod_ext[COUNT_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_speed) begin
      rpm_q <= rpm_abs;
      spm_q <= SpmW'(micro_eff) * SpmW'(StepsPerRev);
    end
    if (cmd_i.mul) divisor_q <= DivisorW'(spm_q) * DivisorW'(rpm_q);
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.scale) scaled_q <= scaled_d;
    if (cmd_i.load_out) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // next motion state
  always_comb begin
    tick_d   = tick_q;
    period_d = period_q;
    steps_d  = steps_q;
    pos_d    = pos_q;
    dir_d    = dir_q;
    mode_d   = mode_q;
    estop_d  = estop_q;
    steps_n  = steps_q;
    span     = argument_i - pos_q;
    can_move = (mode_q == MODE_IDLE) && !estop_q;

    if (cmd_i.apply_op) begin
      unique case (operation_i)
        OP_TICK: begin
          if (mode_q != MODE_IDLE) begin
            if (mode_q == MODE_HOME && home_sw_i) begin
              pos_d   = '0;
              steps_d = '0;
              mode_d  = MODE_IDLE;
            end else begin
              if (tick_q == pulse_ext) begin
                pos_d = dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
                if (mode_q != MODE_RUN) begin
                  steps_n = (steps_q != '0) ? steps_q - 32'd1 : '0;
                  steps_d = steps_n;
                  if (steps_n == '0) begin
                    if (mode_q == MODE_HOME) pos_d = '0;
                    mode_d = MODE_IDLE;
                  end
                end
              end
              tick_d = (tick_q >= period_q) ? '0 : tick_q + COUNT_WIDTH'(1);
            end
          end
        end
        OP_SET_DIR: dir_d = argument_i[0];
        OP_STEP_COUNT: begin
          if (can_move && argument_i != '0) begin
            steps_d = argument_i;
            mode_d  = MODE_COUNT;
          end
        end
        OP_MOVE_TO: begin
          if (can_move && span != '0) begin
            dir_d   = span[31];
            steps_d = span[31] ? (~span + 32'd1) : span;
            mode_d  = MODE_COUNT;
          end
        end
        OP_RUN: begin
          if (can_move) begin
            steps_d = '0;
            mode_d  = MODE_RUN;
          end
        end
        OP_HOME: begin
          if (can_move) begin
            steps_d = '1;
            mode_d  = MODE_HOME;
          end
        end
        OP_STOP: begin
          steps_d = '0;
          mode_d  = MODE_IDLE;
        end
        OP_ESTOP: begin
          steps_d = '0;
          mode_d  = MODE_IDLE;
          estop_d = 1'b1;
        end
        OP_CLEAR_ESTOP: estop_d = 1'b0;
        default: ;  // set_speed with zero rpm and unused codes
      endcase
    end

    if (cmd_i.commit_speed) begin
      period_d = scaled_q;
      tick_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      period_q <= COUNT_WIDTH'(PeriodRst);
      steps_q  <= '0;
      pos_q    <= '1;
      dir_q    <= 1'b0;
      mode_q   <= MODE_IDLE;
      estop_q  <= 1'b0;
    end else begin
      tick_q   <= tick_d;
      period_q <= period_d;
      steps_q  <= steps_d;
      pos_q    <= pos_d;
      dir_q    <= dir_d;
      mode_q   <= mode_d;
      estop_q  <= estop_d;
    end
  end

  // result from the state as it stands after the request
  assign busy_d     = (mode_d != MODE_IDLE);
  assign period_ext = PerW'(period_d);

  always_comb begin
    res_d.step_out      = busy_d && (tick_d < pulse_ext);
    res_d.dir_out       = dir_d;
    res_d.enable_n      = !busy_d;
    res_d.busy_res      = busy_d;
    res_d.position      = pos_d;
    res_d.estop_latched = estop_d;
    res_d.period_ticks  = period_ext[31:0];
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> design/ssg_controller.sv
// Sequencing of requests, speed calculation and result hand-off.
`default_nettype none
`include "stepper_step_generator_macros.svh"
module ssg_controller (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  ssg_pkg::stat_t  stat_i,
  output ssg_pkg::cmd_t   cmd_o
);
  import ssg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_SCALE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          if (stat_i.speed_req) begin
            cmd_o.start_speed = 1'b1;
            state_d           = S_MUL;
          end else begin
            cmd_o.apply_op = 1'b1;
            cmd_o.load_out = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // wait for the result slot before committing the new period
        if (slot_free) begin
          cmd_o.commit_speed = 1'b1;
          cmd_o.load_out     = 1'b1;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SSG_ASSERT_NOW(a_load_slot_free, clk_i, rst_ni, cmd_o.load_out, slot_free)
  `SSG_ASSERT_NEXT(a_speed_enters_mul, clk_i, rst_ni,
                   in_valid_i && in_ready_o && stat_i.speed_req, state_q == S_MUL)
  `SSG_ASSERT_NEXT(a_div_ends_in_scale, clk_i, rst_ni,
                   state_q == S_DIV && stat_i.div_last, state_q == S_SCALE)
  `SSG_ASSERT_NOW(a_ready_only_idle, clk_i, rst_ni, in_ready_o,
                  state_q == S_IDLE && slot_free)

endmodule
`default_nettype wire

>>> design/stepper_step_generator.sv
// Top level of the step/direction pulse generator.
// Every request except a non-zero set_speed is applied as it is taken, which is
// whenever the result register is free or being emptied, so ticks can stream one
// per cycle while results are taken. A set_speed with non-zero rpm occupies the
// block (operand latch, 17x32 divisor multiply, 32 steps of the restoring divider
// at one quotient bit per cycle, scaling by 60 with saturation, commit); no other
// request is taken meanwhile. One result is returned per request. Configuration
// writes take effect at the clock edge they are presented and do not stall.
`default_nettype none
module stepper_step_generator #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [ssg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [ssg_pkg::CfgDataW-1:0] cfg_data_i,
  ssg_in_if.sink                       in_ch,
  ssg_out_if.source                    out_ch
);
  import ssg_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  in_ready;
  logic  out_valid;

  ssg_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ssg_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .operation_i (in_ch.operation),
    .argument_i  (in_ch.argument),
    .home_sw_i   (in_ch.home_sw),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.step_out      = res.step_out;
  assign out_ch.dir_out       = res.dir_out;
  assign out_ch.enable_n      = res.enable_n;
  assign out_ch.busy_res      = res.busy_res;
  assign out_ch.position      = res.position;
  assign out_ch.estop_latched = res.estop_latched;
  assign out_ch.period_ticks  = res.period_ticks;

endmodule
`default_nettype wire
